### rtl/core/pmp_pkg.sv
// Package for the PIM message parser: phase codes, field codes, error codes,
// record type. No dependencies.
`default_nettype none
package pmp_pkg;

  typedef enum logic [4:0] {
    PH_VT, PH_RES, PH_CSUM, PH_OTYPE, PH_HT_LEN, PH_HT_VAL, PH_LPD_LEN, PH_LPD_A,
    PH_DR_LEN, PH_DR_VAL, PH_GID_LEN, PH_GID_VAL, PH_LPD_OVR, PH_REG, PH_GADDR,
    PH_USRC, PH_UORIG, PH_UUP, PH_JP_RES2, PH_JP_NG, PH_JP_HOLD, PH_JP_NJ,
    PH_JP_NP, PH_SADDR, PH_MPREF, PH_METRIC, PH_SR_MASK, PH_SR_TTL, PH_SR_FLAGS,
    PH_SR_INT, PH_DONE
  } phase_t;

  localparam int MaxRec = 6;

  localparam logic [3:0] ERR_NONE = 4'd0;
  localparam logic [3:0] ERR_FAM = 4'd1;
  localparam logic [3:0] ERR_MASK = 4'd2;
  localparam logic [3:0] ERR_OLEN = 4'd3;
  localparam logic [3:0] ERR_TBIT = 4'd4;
  localparam logic [3:0] ERR_GHOLD = 4'd5;
  localparam logic [3:0] ERR_TYPE = 4'd6;
  localparam logic [3:0] ERR_OPT = 4'd7;
  localparam logic [3:0] ERR_TRUNC = 4'd8;

  localparam logic [5:0] F_VER = 6'd0, F_TYPE = 6'd1, F_RSV = 6'd2, F_CSUM = 6'd3;
  localparam logic [5:0] F_OTYPE = 6'd4, F_OLEN = 6'd5, F_HOLD = 6'd6, F_TBIT = 6'd7;
  localparam logic [5:0] F_PDLY = 6'd8, F_OVR = 6'd9, F_DRP = 6'd10, F_GID = 6'd11;
  localparam logic [5:0] F_RB = 6'd12, F_RN = 6'd13, F_RRSV = 6'd14, F_FAM = 6'd15;
  localparam logic [5:0] F_ENC = 6'd16, F_GB = 6'd17, F_GRSV = 6'd18, F_GZ = 6'd19;
  localparam logic [5:0] F_SRSV = 6'd20, F_S = 6'd21, F_W = 6'd22, F_R = 6'd23;
  localparam logic [5:0] F_MASK = 6'd24, F_GADDR = 6'd25, F_USRC = 6'd26, F_UUP = 6'd27;
  localparam logic [5:0] F_ORIG = 6'd28, F_SADDR = 6'd29, F_JRSV = 6'd30, F_NG = 6'd31;
  localparam logic [5:0] F_JHOLD = 6'd32, F_NJ = 6'd33, F_NP = 6'd34, F_ARB = 6'd35;
  localparam logic [5:0] F_MPREF = 6'd36, F_METRIC = 6'd37, F_SRMASK = 6'd38;
  localparam logic [5:0] F_TTL = 6'd39, F_P = 6'd40, F_N = 6'd41, F_O = 6'd42;
  localparam logic [5:0] F_SRRSV = 6'd43, F_INT = 6'd44, F_END = 6'd63;

  localparam logic [7:0] MaskV6 = 8'd128;
  localparam logic [7:0] MaskV4 = 8'd32;

  typedef struct packed {
    logic [5:0]  field_id;
    logic [63:0] field_value;
    logic        address_half;
    logic [7:0]  group_index;
    logic [15:0] source_index;
    logic        source_list;
    logic [3:0]  error_code;
    logic        packet_incorrect;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

endpackage
`default_nettype wire

### rtl/core/pmp_if.sv
// Valid/ready channel interface for the PIM message parser.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface pmp_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/pmp_parse.sv
// Combinational parse step: one byte against the current state gives the
// next state and up to six records. Depends on pmp_pkg.
`default_nettype none
module pmp_parse import pmp_pkg::*; (
  input  wire logic [7:0]  v,
  input  wire logic        lastb,
  input  wire phase_t      ph,
  input  wire logic [4:0]  bif,
  input  wire logic [63:0] acc_in,
  input  wire logic [3:0]  kind,
  input  wire logic        v6,
  input  wire logic [7:0]  gl,
  input  wire logic [15:0] jl,
  input  wire logic [15:0] pl,
  input  wire logic [7:0]  gc,
  input  wire logic [15:0] sc,
  input  wire logic        errs,
  input  wire logic        skip,
  output phase_t           ph_nxt,
  output logic [4:0]       bif_nxt,
  output logic [63:0]      acc_nxt,
  output logic [3:0]       kind_nxt,
  output logic             v6_nxt,
  output logic [7:0]       gl_nxt,
  output logic [15:0]      jl_nxt,
  output logic [15:0]      pl_nxt,
  output logic [7:0]       gc_nxt,
  output logic [15:0]      sc_nxt,
  output logic             errs_nxt,
  output logic             skip_nxt,
  output rec_t [MaxRec-1:0] recs,
  output logic [2:0]       nrec
);

  logic [63:0] acc;
  logic [15:0] w16;
  logic jp, cg, cs, stay, sup, done, whole;
  phase_t nx;
  logic [3:0] t;
  logic [2:0] form;
  logic [4:0] ast, kk;
  logic [7:0] fam;
  logic [5:0] aid;
  logic [2:0] n;

  always_comb begin
    acc = {acc_in[55:0], v};
    w16 = acc[15:0];
    jp = (kind == 4'd3) || (kind == 4'd6) || (kind == 4'd7);
    cg = jp && (ph == PH_GADDR || ph == PH_JP_NJ || ph == PH_JP_NP || ph == PH_SADDR);
    cs = jp && (ph == PH_SADDR);
    t = v[3:0];
    sup = (t <= 4'd3) || t == 4'd5 || t == 4'd6 || t == 4'd7 || t == 4'd9;
    fam = acc_in[7:0];
    ph_nxt = ph; bif_nxt = bif; acc_nxt = acc_in; kind_nxt = kind; v6_nxt = v6;
    gl_nxt = gl; jl_nxt = jl; pl_nxt = pl; gc_nxt = gc; sc_nxt = sc;
    errs_nxt = errs; skip_nxt = skip;
    recs = '0;
    n = 3'd0;
    stay = 1'b1;
    nx = ph;
    done = 1'b0;
    whole = 1'b0;
    form = 3'd0; aid = F_USRC;
    ast = 5'd0; kk = 5'd0;
    if (!skip) begin
      acc_nxt = acc;
      unique case (ph)
        PH_VT: begin
          kind_nxt = t;
          recs[n] = '{F_VER, {60'd0, v[7:4]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                      errs_nxt, 1'b0};
          n = n + 3'd1;
          if (!sup) errs_nxt = 1'b1;
          recs[n] = '{F_TYPE, {60'd0, t}, 1'b0, 8'd0, 16'd0, 1'b0,
                      sup ? ERR_NONE : ERR_TYPE, errs_nxt, 1'b0};
          n = n + 3'd1;
          if (!sup) skip_nxt = 1'b1;
          stay = 1'b0; nx = PH_RES;
        end
        PH_RES: begin
          recs[n] = '{F_RSV, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_CSUM;
        end
        PH_CSUM: if (bif != 5'd0) begin
          recs[n] = '{F_CSUM, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                      1'b0};
          n = n + 3'd1; stay = 1'b0;
          nx = (kind == 4'd0) ? PH_OTYPE : (kind == 4'd1) ? PH_REG : jp ? PH_UUP : PH_GADDR;
        end
        PH_OTYPE: if (bif != 5'd0) begin
          stay = 1'b0;
          priority if (w16 == 16'd1) nx = PH_HT_LEN;
          else if (w16 == 16'd2) nx = PH_LPD_LEN;
          else if (w16 == 16'd19) nx = PH_DR_LEN;
          else if (w16 == 16'd20) nx = PH_GID_LEN;
          else begin
            nx = PH_DONE; errs_nxt = 1'b1; skip_nxt = 1'b1;
          end
          recs[n] = '{F_OTYPE, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0,
                      skip_nxt ? ERR_OPT : ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1;
        end
        PH_HT_LEN, PH_LPD_LEN, PH_DR_LEN, PH_GID_LEN: if (bif != 5'd0) begin
          if (w16 != ((ph == PH_HT_LEN) ? 16'd2 : 16'd4)) errs_nxt = 1'b1;
          recs[n] = '{F_OLEN, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0,
                      (w16 != ((ph == PH_HT_LEN) ? 16'd2 : 16'd4)) ? ERR_OLEN : ERR_NONE,
                      errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = phase_t'(ph + 5'd1);
        end
        PH_HT_VAL: if (bif != 5'd0) begin
          recs[n] = '{F_HOLD, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                      1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_OTYPE;
        end
        PH_LPD_A: begin
          if (bif == 5'd0) begin
            if (v[7]) errs_nxt = 1'b1;
            recs[n] = '{F_TBIT, {63'd0, v[7]}, 1'b0, 8'd0, 16'd0, 1'b0,
                        v[7] ? ERR_TBIT : ERR_NONE, errs_nxt, 1'b0};
            n = n + 3'd1;
          end else begin
            recs[n] = '{F_PDLY, {49'd0, acc[14:0]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                        errs_nxt, 1'b0};
            n = n + 3'd1; stay = 1'b0; nx = PH_LPD_OVR;
          end
        end
        PH_LPD_OVR: if (bif != 5'd0) begin
          recs[n] = '{F_OVR, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                      1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_OTYPE;
        end
        PH_DR_VAL, PH_GID_VAL: if (bif >= 5'd3) begin
          recs[n] = '{(ph == PH_DR_VAL) ? F_DRP : F_GID, {32'd0, acc[31:0]}, 1'b0, 8'd0,
                      16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_OTYPE;
        end
        PH_REG: begin
          if (bif == 5'd0) begin
            recs[0] = '{F_RB, {63'd0, v[7]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                        1'b0};
            recs[1] = '{F_RN, {63'd0, v[6]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                        1'b0};
            n = 3'd2;
          end
          if (bif >= 5'd3) begin
            recs[n] = '{F_RRSV, {34'd0, acc[29:0]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                        errs_nxt, 1'b0};
            n = n + 3'd1; stay = 1'b0; nx = PH_DONE;
          end
        end
        PH_GADDR, PH_USRC, PH_UORIG, PH_UUP, PH_SADDR: begin
          unique case (ph)
            PH_GADDR: begin form = 3'd1; aid = F_GADDR; end
            PH_SADDR: begin form = 3'd2; aid = F_SADDR; end
            PH_UORIG: aid = F_ORIG;
            PH_UUP:   aid = F_UUP;
            default:  aid = F_USRC;
          endcase
          ast = (form != 3'd0) ? 5'd4 : 5'd2;
          if (bif == 5'd0) begin
            v6_nxt = (v == 8'd2);
            recs[n] = '{F_FAM, {56'd0, v}, 1'b0, gc, sc, jl == 16'd0, ERR_NONE, errs_nxt,
                        1'b0};
            n = n + 3'd1;
          end else if (bif == 5'd1) begin
            if (v != 8'd0 || (fam != 8'd1 && fam != 8'd2)) errs_nxt = 1'b1;
            recs[n] = '{F_ENC, {56'd0, v}, 1'b0, gc, sc, jl == 16'd0,
                        (v != 8'd0 || (fam != 8'd1 && fam != 8'd2)) ? ERR_FAM : ERR_NONE,
                        errs_nxt, 1'b0};
            n = n + 3'd1;
          end else if (form == 3'd1 && bif == 5'd2) begin
            recs[0] = '{F_GB, {63'd0, v[7]}, 1'b0, gc, sc, 1'b0, ERR_NONE, errs_nxt, 1'b0};
            recs[1] = '{F_GRSV, {58'd0, v[6:1]}, 1'b0, gc, sc, 1'b0, ERR_NONE, errs_nxt,
                        1'b0};
            recs[2] = '{F_GZ, {63'd0, v[0]}, 1'b0, gc, sc, 1'b0, ERR_NONE, errs_nxt, 1'b0};
            n = 3'd3;
          end else if (form == 3'd2 && bif == 5'd2) begin
            recs[0] = '{F_SRSV, {59'd0, v[7:3]}, 1'b0, gc, sc, jl == 16'd0, ERR_NONE,
                        errs_nxt, 1'b0};
            recs[1] = '{F_S, {63'd0, v[2]}, 1'b0, gc, sc, jl == 16'd0, ERR_NONE, errs_nxt,
                        1'b0};
            recs[2] = '{F_W, {63'd0, v[1]}, 1'b0, gc, sc, jl == 16'd0, ERR_NONE, errs_nxt,
                        1'b0};
            recs[3] = '{F_R, {63'd0, v[0]}, 1'b0, gc, sc, jl == 16'd0, ERR_NONE, errs_nxt,
                        1'b0};
            n = 3'd4;
          end else if (form != 3'd0 && bif == 5'd3) begin
            if (v != (v6 ? MaskV6 : MaskV4)) errs_nxt = 1'b1;
            recs[n] = '{F_MASK, {56'd0, v}, 1'b0, gc, sc, jl == 16'd0,
                        (v != (v6 ? MaskV6 : MaskV4)) ? ERR_MASK : ERR_NONE, errs_nxt,
                        1'b0};
            n = n + 3'd1;
          end
          if (bif >= ast) begin
            kk = bif - ast;
            if (v6 && kk == 5'd7) begin
              recs[n] = '{aid, acc, 1'b0, gc, sc, jl == 16'd0, ERR_NONE, errs_nxt, 1'b0};
              n = n + 3'd1;
            end
            if (kk == (v6 ? 5'd15 : 5'd3)) begin
              recs[n] = '{aid, v6 ? acc : {32'd0, acc[31:0]}, v6, gc, sc, jl == 16'd0,
                          ERR_NONE, errs_nxt, 1'b0};
              n = n + 3'd1;
              done = 1'b1;
            end
          end
          if (done) begin
            stay = 1'b0;
            unique case (ph)
              PH_GADDR: nx = jp ? PH_JP_NJ : PH_USRC;
              PH_USRC:  nx = (kind == 4'd2) ? PH_DONE : (kind == 4'd5) ? PH_MPREF : PH_UORIG;
              PH_UORIG: nx = PH_MPREF;
              PH_UUP:   nx = PH_JP_RES2;
              default: begin
                if (jl != 16'd0) begin
                  jl_nxt = jl - 16'd1;
                  sc_nxt = (jl_nxt != 16'd0) ? sc + 16'd1 : 16'd0;
                end else begin
                  pl_nxt = pl - 16'd1;
                  sc_nxt = sc + 16'd1;
                end
                nx = PH_SADDR;
                if (jl_nxt == 16'd0 && pl_nxt == 16'd0) begin
                  gl_nxt = gl - 8'd1; gc_nxt = gc + 8'd1;
                  nx = (gl_nxt != 8'd0) ? PH_GADDR : PH_DONE;
                end
              end
            endcase
          end
        end
        PH_JP_RES2: begin
          recs[n] = '{F_JRSV, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_JP_NG;
        end
        PH_JP_NG: begin
          recs[n] = '{F_NG, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; gl_nxt = v; gc_nxt = 8'd0; stay = 1'b0; nx = PH_JP_HOLD;
        end
        PH_JP_HOLD: if (bif != 5'd0) begin
          if (kind != 4'd3 && w16 != 16'd0) errs_nxt = 1'b1;
          recs[n] = '{F_JHOLD, {48'd0, w16}, 1'b0, 8'd0, 16'd0, 1'b0,
                      (kind != 4'd3 && w16 != 16'd0) ? ERR_GHOLD : ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = (gl != 8'd0) ? PH_GADDR : PH_DONE;
        end
        PH_JP_NJ: if (bif != 5'd0) begin
          recs[n] = '{F_NJ, {48'd0, w16}, 1'b0, gc, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; jl_nxt = w16; stay = 1'b0; nx = PH_JP_NP;
        end
        PH_JP_NP: if (bif != 5'd0) begin
          recs[n] = '{F_NP, {48'd0, w16}, 1'b0, gc, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; pl_nxt = w16; sc_nxt = 16'd0; stay = 1'b0; nx = PH_SADDR;
          if (jl == 16'd0 && w16 == 16'd0) begin
            gl_nxt = gl - 8'd1; gc_nxt = gc + 8'd1;
            nx = (gl_nxt != 8'd0) ? PH_GADDR : PH_DONE;
          end
        end
        PH_MPREF: begin
          if (bif == 5'd0) begin
            recs[n] = '{F_ARB, {63'd0, v[7]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                        1'b0};
            n = n + 3'd1;
          end
          if (bif >= 5'd3) begin
            recs[n] = '{F_MPREF, {33'd0, acc[30:0]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                        errs_nxt, 1'b0};
            n = n + 3'd1; stay = 1'b0; nx = PH_METRIC;
          end
        end
        PH_METRIC: if (bif >= 5'd3) begin
          recs[n] = '{F_METRIC, {32'd0, acc[31:0]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                      errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = (kind == 4'd9) ? PH_SR_MASK : PH_DONE;
        end
        PH_SR_MASK: begin
          recs[n] = '{F_SRMASK, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt,
                      1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_SR_TTL;
        end
        PH_SR_TTL: begin
          recs[n] = '{F_TTL, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_SR_FLAGS;
        end
        PH_SR_FLAGS: begin
          recs[0] = '{F_P, {63'd0, v[7]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          recs[1] = '{F_N, {63'd0, v[6]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          recs[2] = '{F_O, {63'd0, v[5]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          recs[3] = '{F_SRRSV, {59'd0, v[4:0]}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE,
                      errs_nxt, 1'b0};
          n = 3'd4; stay = 1'b0; nx = PH_SR_INT;
        end
        PH_SR_INT: begin
          recs[n] = '{F_INT, {56'd0, v}, 1'b0, 8'd0, 16'd0, 1'b0, ERR_NONE, errs_nxt, 1'b0};
          n = n + 3'd1; stay = 1'b0; nx = PH_DONE;
        end
        default: begin
          stay = 1'b0; nx = PH_DONE;
        end
      endcase
      for (int i = 0; i < MaxRec; i++) begin
        if (!cg) recs[i].group_index = 8'd0;
        if (!cs) begin
          recs[i].source_index = 16'd0;
          recs[i].source_list = 1'b0;
        end
      end
      if (stay) begin
        bif_nxt = bif + 5'd1;
      end else begin
        ph_nxt = nx; bif_nxt = 5'd0;
      end
    end
    if (lastb) begin
      whole = skip_nxt || ph_nxt == PH_DONE || (ph_nxt == PH_OTYPE && bif_nxt == 5'd0);
      recs[n] = '{F_END, 64'd0, 1'b0, 8'd0, 16'd0, 1'b0, whole ? ERR_NONE : ERR_TRUNC,
                  errs_nxt | !whole, 1'b1};
      n = n + 3'd1;
      ph_nxt = PH_VT; bif_nxt = '0; acc_nxt = '0; kind_nxt = '0; v6_nxt = 1'b0;
      gl_nxt = '0; jl_nxt = '0; pl_nxt = '0; gc_nxt = '0; sc_nxt = '0;
      errs_nxt = 1'b0; skip_nxt = 1'b0;
    end
    nrec = n;
  end

endmodule
`default_nettype wire

### rtl/core/pim_message_parser.sv
// PIM message parser top level: input register, parse step, record queue.
// Depends on pmp_pkg, pmp_if and pmp_parse.
// A transferred byte is held in the input register; its records (up to six)
// enter the record queue while in_ch.ready is high, and are offered from the
// queue head. One byte is accepted per cycle while the queue holds at most
// QDepth - 2*MaxRec records (four at the default depth), leaving room for the
// byte in the input register and the one arriving; records leave one per cycle
// while the receiver is ready, so the sustained rate is one byte per cycle until
// bytes yield more than one record each, then set by the one-record-per-cycle output port.
`default_nettype none
module pim_message_parser import pmp_pkg::*; #(
  parameter int QDepth = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  pmp_if.sink      in_ch,
  pmp_if.source    out_ch
);

  localparam int QW = $clog2(QDepth);

  phase_t ph_r, ph_nxt;
  logic [4:0]  bif_r, bif_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic        v6_r, v6_nxt;
  logic [7:0]  gl_r, gl_nxt, gc_r, gc_nxt;
  logic [15:0] jl_r, jl_nxt, pl_r, pl_nxt, sc_r, sc_nxt;
  logic        errs_r, errs_nxt, skip_r, skip_nxt;
  rec_t [MaxRec-1:0] recs;
  logic [2:0]  nrec;

  in_t  in_r;
  logic in_v_r;

  rec_t q_r [QDepth];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic          pop;
  logic [QW:0]   push_n;

  assign in_ch.ready = !in_v_r || (cnt_r <= (QW+1)'(QDepth - 2*MaxRec));

  pmp_parse u_parse (
    .v(in_r.data_byte), .lastb(in_r.last_byte), .ph(ph_r), .bif(bif_r), .acc_in(acc_r),
    .kind(kind_r), .v6(v6_r), .gl(gl_r), .jl(jl_r), .pl(pl_r), .gc(gc_r), .sc(sc_r),
    .errs(errs_r), .skip(skip_r), .ph_nxt(ph_nxt), .bif_nxt(bif_nxt), .acc_nxt(acc_nxt),
    .kind_nxt(kind_nxt), .v6_nxt(v6_nxt), .gl_nxt(gl_nxt), .jl_nxt(jl_nxt),
    .pl_nxt(pl_nxt), .gc_nxt(gc_nxt), .sc_nxt(sc_nxt), .errs_nxt(errs_nxt),
    .skip_nxt(skip_nxt), .recs(recs), .nrec(nrec)
  );

  assign pop = out_ch.valid && out_ch.ready;
  assign push_n = in_v_r ? (QW+1)'(nrec) : '0;
  assign out_ch.valid = cnt_r != '0;
  assign out_ch.data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.ready) in_r <= in_ch.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_VT; bif_r <= '0; acc_r <= '0; kind_r <= '0; v6_r <= 1'b0;
      gl_r <= '0; jl_r <= '0; pl_r <= '0; gc_r <= '0; sc_r <= '0;
      errs_r <= 1'b0; skip_r <= 1'b0;
    end else if (in_v_r && in_ch.ready) begin
      ph_r <= ph_nxt; bif_r <= bif_nxt; acc_r <= acc_nxt; kind_r <= kind_nxt;
      v6_r <= v6_nxt; gl_r <= gl_nxt; jl_r <= jl_nxt; pl_r <= pl_nxt; gc_r <= gc_nxt;
      sc_r <= sc_nxt; errs_r <= errs_nxt; skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r && in_ch.ready) begin
      for (int i = 0; i < MaxRec; i++) begin
        if (3'(i) < nrec) q_r[wp_r + QW'(i)] <= recs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (in_v_r && in_ch.ready) wp_r <= wp_r + QW'(nrec);
      if (pop) rp_r <= rp_r + QW'(1);
      cnt_r <= cnt_r + ((in_v_r && in_ch.ready) ? push_n : '0) - (QW+1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(QDepth)) else $error("record queue overflow");
  a_nrec: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> nrec <= 3'(MaxRec)) else $error("too many records");
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && in_ch.ready && in_r.last_byte) |=> (ph_r == PH_VT && !errs_r))
    else $error("state not cleared after message end");
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !out_ch.valid) else $error("valid with empty queue");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for pim_message_parser: drives whole and broken PIM messages byte by
// byte and checks every field record against a predictor of the parse.
// Depends on pmp_pkg, pmp_if and pim_message_parser.
`timescale 1ns / 1ps

import pmp_pkg::*;

class pim_scoreboard;
  phase_t      phase;
  logic [4:0]  bif;
  logic [63:0] acc;
  logic [3:0]  kind;
  bit          v6;
  logic [7:0]  groups_left, group_cnt;
  logic [15:0] joined_left, pruned_left, source_cnt;
  bit          err_seen, skip, ctx_grp, ctx_src;
  int          nrec;
  rec_t        pending[$];
  int          errors;

  function new();
    clear_msg();
    errors = 0;
  endfunction

  function void clear_msg();
    phase = PH_VT; bif = 0; acc = 0; kind = 0; v6 = 0;
    groups_left = 0; group_cnt = 0; joined_left = 0; pruned_left = 0;
    source_cnt = 0; err_seen = 0; skip = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function void emit(logic [5:0] id, logic [63:0] val, bit half, logic [3:0] err, bit lst);
    rec_t r;
    if (err != ERR_NONE) err_seen = 1;
    if (nrec >= MaxRec) return;
    r.field_id = id;
    r.field_value = val;
    r.address_half = half;
    r.group_index = ctx_grp ? group_cnt : 8'd0;
    r.source_index = ctx_src ? source_cnt : 16'd0;
    r.source_list = ctx_src ? (joined_left == 0) : 1'b0;
    r.error_code = err;
    r.packet_incorrect = err_seen;
    r.last = lst;
    pending.push_back(r);
    nrec++;
  endfunction

  function bit addr_step(int form, logic [5:0] id, logic [7:0] v);
    int k, alen, astart;
    logic [7:0] fam;
    astart = (form != 0) ? 4 : 2;
    if (bif == 0) begin
      v6 = (v == 8'd2);
      emit(F_FAM, v, 0, ERR_NONE, 0);
    end else if (bif == 1) begin
      fam = acc[15:8];
      emit(F_ENC, v, 0, (v != 0 || (fam != 1 && fam != 2)) ? ERR_FAM : ERR_NONE, 0);
    end else if (form == 1 && bif == 2) begin
      emit(F_GB, v[7], 0, ERR_NONE, 0);
      emit(F_GRSV, v[6:1], 0, ERR_NONE, 0);
      emit(F_GZ, v[0], 0, ERR_NONE, 0);
    end else if (form == 2 && bif == 2) begin
      emit(F_SRSV, v[7:3], 0, ERR_NONE, 0);
      emit(F_S, v[2], 0, ERR_NONE, 0);
      emit(F_W, v[1], 0, ERR_NONE, 0);
      emit(F_R, v[0], 0, ERR_NONE, 0);
    end else if (form != 0 && bif == 3) begin
      emit(F_MASK, v, 0, (v != (v6 ? MaskV6 : MaskV4)) ? ERR_MASK : ERR_NONE, 0);
    end
    if (bif >= astart) begin
      k = bif - astart;
      alen = v6 ? 16 : 4;
      if (v6 && k == 7) emit(id, acc, 0, ERR_NONE, 0);
      if (k == alen - 1) begin
        emit(id, v6 ? acc : {32'd0, acc[31:0]}, v6, ERR_NONE, 0);
        return 1;
      end
    end
    return 0;
  endfunction

  function phase_t source_next();
    if (joined_left != 0 || pruned_left != 0) return PH_SADDR;
    groups_left--;
    group_cnt++;
    return (groups_left != 0) ? PH_GADDR : PH_DONE;
  endfunction

  // returns 1 and sets nxt when the phase completes
  function bit parse(logic [7:0] v, output phase_t nxt);
    bit jp;
    logic [15:0] w16;
    logic [3:0] t;
    bit sup;
    jp = (kind == 3 || kind == 6 || kind == 7);
    w16 = acc[15:0];
    nxt = PH_DONE;
    case (phase)
      PH_VT: begin
        t = v[3:0];
        sup = (t <= 3 || t == 5 || t == 6 || t == 7 || t == 9);
        kind = t;
        emit(F_VER, v[7:4], 0, ERR_NONE, 0);
        emit(F_TYPE, t, 0, sup ? ERR_NONE : ERR_TYPE, 0);
        if (!sup) skip = 1;
        nxt = PH_RES;
      end
      PH_RES: begin
        emit(F_RSV, v, 0, ERR_NONE, 0);
        nxt = PH_CSUM;
      end
      PH_CSUM: begin
        if (bif < 1) return 0;
        emit(F_CSUM, w16, 0, ERR_NONE, 0);
        nxt = (kind == 0) ? PH_OTYPE : (kind == 1) ? PH_REG : jp ? PH_UUP : PH_GADDR;
      end
      PH_OTYPE: begin
        if (bif < 1) return 0;
        case (w16)
          16'd1: nxt = PH_HT_LEN;
          16'd2: nxt = PH_LPD_LEN;
          16'd19: nxt = PH_DR_LEN;
          16'd20: nxt = PH_GID_LEN;
          default: begin
            skip = 1;
            nxt = PH_DONE;
          end
        endcase
        emit(F_OTYPE, w16, 0, (nxt == PH_DONE) ? ERR_OPT : ERR_NONE, 0);
      end
      PH_HT_LEN, PH_LPD_LEN, PH_DR_LEN, PH_GID_LEN: begin
        if (bif < 1) return 0;
        emit(F_OLEN, w16, 0,
             (w16 != ((phase == PH_HT_LEN) ? 16'd2 : 16'd4)) ? ERR_OLEN : ERR_NONE, 0);
        nxt = phase_t'(phase + 1);
      end
      PH_HT_VAL: begin
        if (bif < 1) return 0;
        emit(F_HOLD, w16, 0, ERR_NONE, 0);
        nxt = PH_OTYPE;
      end
      PH_LPD_A: begin
        if (bif == 0) begin
          emit(F_TBIT, v[7], 0, v[7] ? ERR_TBIT : ERR_NONE, 0);
          return 0;
        end
        emit(F_PDLY, acc[14:0], 0, ERR_NONE, 0);
        nxt = PH_LPD_OVR;
      end
      PH_LPD_OVR: begin
        if (bif < 1) return 0;
        emit(F_OVR, w16, 0, ERR_NONE, 0);
        nxt = PH_OTYPE;
      end
      PH_DR_VAL, PH_GID_VAL: begin
        if (bif < 3) return 0;
        emit((phase == PH_DR_VAL) ? F_DRP : F_GID, acc[31:0], 0, ERR_NONE, 0);
        nxt = PH_OTYPE;
      end
      PH_REG: begin
        if (bif == 0) begin
          emit(F_RB, v[7], 0, ERR_NONE, 0);
          emit(F_RN, v[6], 0, ERR_NONE, 0);
        end
        if (bif < 3) return 0;
        emit(F_RRSV, acc[29:0], 0, ERR_NONE, 0);
        nxt = PH_DONE;
      end
      PH_GADDR: begin
        if (!addr_step(1, F_GADDR, v)) return 0;
        nxt = jp ? PH_JP_NJ : PH_USRC;
      end
      PH_USRC: begin
        if (!addr_step(0, F_USRC, v)) return 0;
        nxt = (kind == 2) ? PH_DONE : (kind == 5) ? PH_MPREF : PH_UORIG;
      end
      PH_UORIG: begin
        if (!addr_step(0, F_ORIG, v)) return 0;
        nxt = PH_MPREF;
      end
      PH_UUP: begin
        if (!addr_step(0, F_UUP, v)) return 0;
        nxt = PH_JP_RES2;
      end
      PH_JP_RES2: begin
        emit(F_JRSV, v, 0, ERR_NONE, 0);
        nxt = PH_JP_NG;
      end
      PH_JP_NG: begin
        emit(F_NG, v, 0, ERR_NONE, 0);
        groups_left = v;
        group_cnt = 0;
        nxt = PH_JP_HOLD;
      end
      PH_JP_HOLD: begin
        if (bif < 1) return 0;
        emit(F_JHOLD, w16, 0, (kind != 3 && w16 != 0) ? ERR_GHOLD : ERR_NONE, 0);
        nxt = (groups_left != 0) ? PH_GADDR : PH_DONE;
      end
      PH_JP_NJ: begin
        if (bif < 1) return 0;
        emit(F_NJ, w16, 0, ERR_NONE, 0);
        joined_left = w16;
        nxt = PH_JP_NP;
      end
      PH_JP_NP: begin
        if (bif < 1) return 0;
        emit(F_NP, w16, 0, ERR_NONE, 0);
        pruned_left = w16;
        source_cnt = 0;
        nxt = source_next();
      end
      PH_SADDR: begin
        if (!addr_step(2, F_SADDR, v)) return 0;
        if (joined_left != 0) begin
          joined_left--;
          source_cnt = (joined_left != 0) ? source_cnt + 16'd1 : 16'd0;
        end else begin
          pruned_left--;
          source_cnt++;
        end
        nxt = source_next();
      end
      PH_MPREF: begin
        if (bif == 0) emit(F_ARB, v[7], 0, ERR_NONE, 0);
        if (bif < 3) return 0;
        emit(F_MPREF, acc[30:0], 0, ERR_NONE, 0);
        nxt = PH_METRIC;
      end
      PH_METRIC: begin
        if (bif < 3) return 0;
        emit(F_METRIC, acc[31:0], 0, ERR_NONE, 0);
        nxt = (kind == 9) ? PH_SR_MASK : PH_DONE;
      end
      PH_SR_MASK: begin
        emit(F_SRMASK, v, 0, ERR_NONE, 0);
        nxt = PH_SR_TTL;
      end
      PH_SR_TTL: begin
        emit(F_TTL, v, 0, ERR_NONE, 0);
        nxt = PH_SR_FLAGS;
      end
      PH_SR_FLAGS: begin
        emit(F_P, v[7], 0, ERR_NONE, 0);
        emit(F_N, v[6], 0, ERR_NONE, 0);
        emit(F_O, v[5], 0, ERR_NONE, 0);
        emit(F_SRRSV, v[4:0], 0, ERR_NONE, 0);
        nxt = PH_SR_INT;
      end
      PH_SR_INT: begin
        emit(F_INT, v, 0, ERR_NONE, 0);
        nxt = PH_DONE;
      end
      default: nxt = PH_DONE;
    endcase
    return 1;
  endfunction

  function void note_byte(in_t item);
    bit jp, whole;
    phase_t nxt;
    jp = (kind == 3 || kind == 6 || kind == 7);
    nrec = 0;
    ctx_grp = jp && (phase == PH_GADDR || phase == PH_JP_NJ ||
                     phase == PH_JP_NP || phase == PH_SADDR);
    ctx_src = jp && phase == PH_SADDR;
    if (!skip) begin
      acc = {acc[55:0], item.data_byte};
      if (parse(item.data_byte, nxt)) begin
        phase = nxt;
        bif = 0;
      end else begin
        bif++;
      end
    end
    if (item.last_byte) begin
      whole = skip || phase == PH_DONE || (phase == PH_OTYPE && bif == 0);
      ctx_grp = 0;
      ctx_src = 0;
      emit(F_END, 64'd0, 0, whole ? ERR_NONE : ERR_TRUNC, 1);
      clear_msg();
    end
  endfunction

  task check_record(rec_t got);
    rec_t exp_r;
    if (pending.size() == 0) begin
      report($sformatf("unexpected record id %0d", got.field_id));
      return;
    end
    exp_r = pending.pop_front();
    if (got.field_id !== exp_r.field_id)
      report($sformatf("field_id %0d, want %0d", got.field_id, exp_r.field_id));
    if (got.field_value !== exp_r.field_value)
      report($sformatf("id %0d value %h, want %h", exp_r.field_id, got.field_value,
                       exp_r.field_value));
    if (got.address_half !== exp_r.address_half)
      report($sformatf("id %0d address_half %b", exp_r.field_id, got.address_half));
    if (got.group_index !== exp_r.group_index)
      report($sformatf("id %0d group_index %0d, want %0d", exp_r.field_id,
                       got.group_index, exp_r.group_index));
    if (got.source_index !== exp_r.source_index)
      report($sformatf("id %0d source_index %0d, want %0d", exp_r.field_id,
                       got.source_index, exp_r.source_index));
    if (got.source_list !== exp_r.source_list)
      report($sformatf("id %0d source_list %b", exp_r.field_id, got.source_list));
    if (got.error_code !== exp_r.error_code)
      report($sformatf("id %0d error_code %0d, want %0d", exp_r.field_id,
                       got.error_code, exp_r.error_code));
    if (got.packet_incorrect !== exp_r.packet_incorrect)
      report($sformatf("id %0d packet_incorrect %b", exp_r.field_id,
                       got.packet_incorrect));
    if (got.last !== exp_r.last)
      report($sformatf("id %0d last %b", exp_r.field_id, got.last));
  endtask
endclass

module tb_top;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   bytes_sent = 0;
  bit   hold_req = 1'b0;
  bit   quiet_sender = 1'b0;
  bit   quiet_receiver = 1'b0;
  logic [7:0] msg[$];
  pim_scoreboard sb;

  pmp_if #(.T(in_t))  in_if (clk);
  pmp_if #(.T(rec_t)) out_if (clk);

  pim_message_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_byte(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_record(out_if.data);
  end

  initial begin : receiver
    int wait_n;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_n = quiet_receiver ? 0 : $urandom_range(19);
      if (wait_n > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic bit rare(int n);
    return $urandom_range(n - 1) == 0;
  endfunction

  function automatic void put_rand(int n);
    repeat (n) msg.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put16(logic [15:0] w);
    msg.push_back(w[15:8]);
    msg.push_back(w[7:0]);
  endfunction

  // form 0 unicast, 1 group, 2 source
  function automatic void put_addr(int form);
    logic [7:0] fam;
    fam = $urandom_range(1) ? 8'd2 : 8'd1;
    if (rare(10)) fam = 8'($urandom_range(255));
    msg.push_back(fam);
    msg.push_back(rare(10) ? 8'($urandom_range(255)) : 8'd0);
    if (form != 0) begin
      put_rand(1);
      if (rare(8)) put_rand(1);
      else msg.push_back((fam == 8'd2) ? MaskV6 : MaskV4);
    end
    put_rand((fam == 8'd2) ? 16 : 4);
  endfunction

  function automatic void put_header(logic [3:0] t);
    msg.push_back({rare(6) ? 4'($urandom_range(15)) : 4'd2, t});
    put_rand(3);
  endfunction

  function automatic void build_message();
    int t, n, nj, np;
    logic [15:0] opt;
    msg.delete();
    case ($urandom_range(9))
      0: t = 0;
      1: t = 1;
      2: t = 2;
      3, 4: t = 3;
      5: t = 5;
      6: t = 6;
      7: t = 7;
      8: t = 9;
      default: t = rare(3) ? 4 : $urandom_range(15);
    endcase
    put_header(4'(t));
    case (t)
      0: repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0: opt = 16'd1;
          1: opt = 16'd2;
          2: opt = 16'd19;
          default: opt = 16'd20;
        endcase
        if (rare(10)) opt = 16'($urandom_range(65535));
        put16(opt);
        if (rare(8)) put16(16'($urandom_range(65535)));
        else put16((opt == 16'd1) ? 16'd2 : 16'd4);
        if (opt == 16'd2) msg.push_back(rare(4) ? 8'($urandom_range(255)) :
                                        8'($urandom_range(127)));
        put_rand((opt == 16'd1) ? 2 : (opt == 16'd2) ? 3 : 4);
      end
      1: put_rand(4);
      2: begin
        put_addr(1);
        put_addr(0);
      end
      3, 6, 7: begin
        put_addr(0);
        put_rand(1);
        n = $urandom_range(2);
        msg.push_back(8'(n));
        put16((t == 3 || rare(4)) ? 16'($urandom_range(65535)) : 16'd0);
        repeat (n) begin
          put_addr(1);
          nj = $urandom_range(2);
          np = $urandom_range(2);
          put16(rare(10) ? 16'($urandom_range(65535)) : 16'(nj));
          put16(16'(np));
          repeat (nj + np) put_addr(2);
        end
      end
      5, 9: begin
        put_addr(1);
        put_addr(0);
        if (t == 9) put_addr(0);
        put_rand(8);
        if (t == 9) put_rand(4);
      end
      default: put_rand($urandom_range(4));
    endcase
    if (rare(6)) begin
      n = $urandom_range(msg.size());
      while (msg.size() > n && msg.size() > 1) void'(msg.pop_back());
    end
    if (rare(6)) put_rand($urandom_range(1, 3));
  endfunction

  task automatic send_byte(logic [7:0] b, bit lst);
    int gap;
    in_t item;
    gap = quiet_sender ? 0 : $urandom_range(19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = b;
    item.last_byte = lst;
    in_if.data <= item;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_list(logic [7:0] bl[$]);
    msg = bl;
    send_message();
  endtask

  initial begin : stimulus
    int msgs;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: field extremes, unsupported type, truncation, trailing bytes
    send_list('{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h02, 8'hFF, 8'hFF});
    send_list('{8'hFF, 8'h00, 8'h12, 8'h34});
    send_list('{8'h21, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA});
    send_list('{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_list('{8'h20});
    send_list('{8'h20, 8'h00, 8'h00, 8'h00, 8'hAB});
    msgs = 0;
    while (bytes_sent < 210) begin
      build_message();
      quiet_sender = rare(4);
      quiet_receiver = rare(4);
      if (msgs == 2) begin
        hold_req = 1'b1;
        quiet_sender = 1'b1;
      end
      if (msgs == 5) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_message();
      msgs++;
    end
    in_if.valid <= 1'b0;
    quiet_receiver = 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
